[sv/strd_pkg.sv]
`timescale 1ns / 1ps

package strd_pkg;

  localparam logic [3:0] HEADER_BYTES_RESET = 4'd10;
  localparam logic [7:0] SYNC_VALUE_RESET   = 8'h55;

  // register index taken from paddr[2]
  localparam logic REG_HEADER_BYTES = 1'b0;
  localparam logic REG_SYNC_VALUE   = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RECHEAD,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_SYNC_ERR,
    CMD_TRUNC
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [3:0]  rec_type;
    logic [11:0] rec_id;
    logic [6:0]  payload_length;
    logic        update_bit;
    logic [7:0]  payload_byte;
    logic [6:0]  byte_position;
    logic        byte_valid;
    logic        record_end;
    logic        sync_error;
    logic        truncated;
  } out_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [6:0]  pos;
    logic        final_byte;
    logic        trunc;
    logic [15:0] type_id;
    logic [6:0]  length;
    logic        update;
  } cmd_t;

endpackage

[sv/sync_tagged_record_deframer.sv]
`timescale 1ns / 1ps

// path: a byte's result is held in the queue and then in the output register
// throughput: one byte per cycle while full is low, set by the parser in the front stage
// a two-entry queue and the output register let either side stall on its own
// reset: synchronous, active high; clears parser, queue and output state at once
// and sets header_bytes to 10 and sync_value to 0x55

module sync_tagged_record_deframer (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  strd_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output strd_pkg::out_t result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [3:0]     header_bytes;
  logic [7:0]     sync_value;
  logic           cfg_write;
  logic           accept;
  logic           cmd_valid;
  strd_pkg::cmd_t cmd_front;
  strd_pkg::cmd_t cmd_queued;
  logic           q_full;
  logic           q_not_empty;
  logic           q_take;
  logic           q_wr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= strd_pkg::HEADER_BYTES_RESET;
      sync_value   <= strd_pkg::SYNC_VALUE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        strd_pkg::REG_HEADER_BYTES: header_bytes <= pwdata[3:0];
        strd_pkg::REG_SYNC_VALUE:   sync_value   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      strd_pkg::REG_HEADER_BYTES: prdata = {28'd0, header_bytes};
      strd_pkg::REG_SYNC_VALUE:   prdata = {24'd0, sync_value};
      default:                    prdata = 32'd0;
    endcase
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept && cmd_valid;

  strd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .header_bytes (header_bytes),
    .sync_value   (sync_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd_front)
  );

  strd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr),
    .wr_data   (cmd_front),
    .full      (q_full),
    .rd_en     (q_take),
    .rd_data   (cmd_queued),
    .not_empty (q_not_empty)
  );

  strd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_ready (q_not_empty),
    .cmd       (cmd_queued),
    .cmd_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_wr && q_full))
    else $error("queue written while full");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.byte_valid) |->
      (result.payload_byte == 8'd0 && result.byte_position == 7'd0))
    else $error("payload fields set on a result without a payload byte");

  a_end_not_truncated: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(result.record_end && result.truncated))
    else $error("record end and truncation on the same result");

  a_sync_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.sync_error) |-> (!result.byte_valid && !result.record_end))
    else $error("sync error result carries payload or record end");

endmodule

[sv/strd_front.sv]
`timescale 1ns / 1ps

module strd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  strd_pkg::in_t item,
  input  logic [3:0]    header_bytes,
  input  logic [7:0]    sync_value,
  output logic          cmd_valid,
  output strd_pkg::cmd_t cmd
);

  strd_pkg::phase_t phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic        sync_good, sync_good_next;
  logic [15:0] type_id_word, type_id_word_next;
  logic [6:0]  length_reg, length_reg_next;
  logic        update_reg, update_reg_next;
  logic [6:0]  payload_count, payload_count_next;
  logic [1:0]  record_start_count, record_start_count_next;

  logic        in_rechead;
  logic [1:0]  rsc_eff;
  logic [7:0]  pos_plus;
  logic        final_byte;
  logic        len_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= strd_pkg::PH_HEADER;
      header_count       <= 4'd0;
      sync_good          <= 1'b0;
      type_id_word       <= 16'd0;
      length_reg         <= 7'd0;
      update_reg         <= 1'b0;
      payload_count      <= 7'd0;
      record_start_count <= 2'd0;
    end else if (accept) begin
      phase              <= phase_next;
      header_count       <= header_count_next;
      sync_good          <= sync_good_next;
      type_id_word       <= type_id_word_next;
      length_reg         <= length_reg_next;
      update_reg         <= update_reg_next;
      payload_count      <= payload_count_next;
      record_start_count <= record_start_count_next;
    end
  end

  assign pos_plus   = {1'b0, payload_count} + 8'd1;
  assign final_byte = pos_plus >= {1'b0, length_reg};
  assign len_nz     = item.in_byte[6:0] != 7'd0;

  always_comb begin
    phase_next              = phase;
    header_count_next       = header_count;
    sync_good_next          = sync_good;
    type_id_word_next       = type_id_word;
    length_reg_next         = length_reg;
    update_reg_next         = update_reg;
    payload_count_next      = payload_count;
    record_start_count_next = record_start_count;
    cmd_valid    = 1'b0;
    cmd.kind     = strd_pkg::CMD_BYTE;
    cmd.data     = 8'd0;
    cmd.pos      = 7'd0;
    cmd.final_byte = 1'b0;
    cmd.trunc    = 1'b0;
    cmd.type_id  = type_id_word;
    cmd.length   = length_reg;
    cmd.update   = update_reg;
    in_rechead   = 1'b0;
    rsc_eff      = record_start_count;

    case (phase)
      strd_pkg::PH_HEADER: begin
        if (header_count < header_bytes) begin
          header_count_next = header_count + 4'd1;
        end else begin
          // header done: this byte already opens the first record
          in_rechead = 1'b1;
          rsc_eff    = 2'd0;
        end
      end
      strd_pkg::PH_RECHEAD: in_rechead = 1'b1;
      strd_pkg::PH_PAYLOAD: begin
        if (sync_good) begin
          cmd_valid      = 1'b1;
          cmd.kind       = strd_pkg::CMD_BYTE;
          cmd.data       = item.in_byte;
          cmd.pos        = payload_count;
          cmd.final_byte = final_byte;
          cmd.trunc      = item.frame_last && !final_byte;
        end else if (item.frame_last && !final_byte) begin
          cmd_valid = 1'b1;
          cmd.kind  = strd_pkg::CMD_TRUNC;
          cmd.trunc = 1'b1;
        end
        payload_count_next = pos_plus[6:0];
        if (final_byte) begin
          phase_next              = strd_pkg::PH_RECHEAD;
          record_start_count_next = 2'd0;
          payload_count_next      = 7'd0;
        end
      end
      default: phase_next = strd_pkg::PH_HEADER;
    endcase

    if (in_rechead) begin
      phase_next = strd_pkg::PH_RECHEAD;
      case (rsc_eff)
        2'd0: begin
          sync_good_next          = item.in_byte == sync_value;
          record_start_count_next = 2'd1;
        end
        2'd1: begin
          type_id_word_next[15:8] = item.in_byte;
          record_start_count_next = 2'd2;
        end
        2'd2: begin
          type_id_word_next[7:0]  = item.in_byte;
          record_start_count_next = 2'd3;
        end
        default: begin
          length_reg_next         = item.in_byte[6:0];
          update_reg_next         = item.in_byte[7];
          record_start_count_next = 2'd0;
          payload_count_next      = 7'd0;
          cmd.length = item.in_byte[6:0];
          cmd.update = item.in_byte[7];
          if (sync_good) begin
            if (!len_nz) begin
              cmd_valid = 1'b1;
              cmd.kind  = strd_pkg::CMD_END;
            end else if (item.frame_last) begin
              cmd_valid = 1'b1;
              cmd.kind  = strd_pkg::CMD_TRUNC;
              cmd.trunc = 1'b1;
            end
          end else begin
            cmd_valid = 1'b1;
            cmd.kind  = strd_pkg::CMD_SYNC_ERR;
            cmd.trunc = item.frame_last && len_nz;
          end
          if (len_nz) begin
            phase_next = strd_pkg::PH_PAYLOAD;
          end
        end
      endcase
    end

    if (item.frame_last) begin
      phase_next              = strd_pkg::PH_HEADER;
      header_count_next       = 4'd0;
      record_start_count_next = 2'd0;
      payload_count_next      = 7'd0;
    end
  end

endmodule

[sv/strd_queue.sv]
`timescale 1ns / 1ps

module strd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  strd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output strd_pkg::cmd_t rd_data,
  output logic           not_empty
);

  strd_pkg::cmd_t entries [strd_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assign full      = count == 2'(strd_pkg::QUEUE_DEPTH);
  assign not_empty = count != 2'd0;
  assign rd_data   = entries[rd_ptr];

endmodule

[sv/strd_back.sv]
`timescale 1ns / 1ps

module strd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_ready,
  input  strd_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  logic           pop,
  output logic           empty,
  output strd_pkg::out_t result
);

  logic           out_valid;
  strd_pkg::out_t result_next;
  logic           is_data;

  assign cmd_take = cmd_ready && (!out_valid || pop);
  assign empty    = !out_valid;
  assign is_data  = cmd.kind == strd_pkg::CMD_BYTE;

  always_comb begin
    result_next.rec_type       = cmd.type_id[15:12];
    result_next.rec_id         = cmd.type_id[11:0];
    result_next.payload_length = cmd.length;
    result_next.update_bit     = cmd.update;
    result_next.payload_byte   = is_data ? cmd.data : 8'd0;
    result_next.byte_position  = is_data ? cmd.pos : 7'd0;
    result_next.byte_valid     = is_data;
    result_next.record_end     = (is_data && cmd.final_byte) ||
                                 cmd.kind == strd_pkg::CMD_END;
    result_next.sync_error     = cmd.kind == strd_pkg::CMD_SYNC_ERR;
    result_next.truncated      = cmd.trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      result <= result_next;
    end
  end

endmodule
